// ----- hdl/dsnf_pkg.sv -----
// Shared types and constants for the 8.3 short name formatter.
// No dependencies; used by dsnf_front, dsnf_fifo, dsnf_back and the top level.
package dsnf_pkg;

    // Positions cover the whole short name for every supported length (up to 31).
    localparam int POS_W = 5;
    typedef logic [POS_W-1:0] pos_t;

    localparam int Q_DEPTH = 4;
    localparam int Q_IDX_W = 2;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // One request from front to back: an optional character, then spaces at
    // positions pad_lo .. pad_hi-1.
    typedef struct packed {
        logic       has_char;
        logic [7:0] ch;
        pos_t       ch_pos;
        pos_t       pad_lo;
        pos_t       pad_hi;
    } cmd_t;

endpackage

// ----- hdl/dos_short_name_formatter_core.sv -----
// 8.3 short name formatter: takes a long file name a byte per request (zero
// ends the name) and streams out the space-padded short name, one byte per
// request with its position. Input is taken while the request queue is not
// full; a mapped character flows from the queue through the active request
// register into the output register, one per cycle while the output is not
// stalled. A dot or the terminating zero expands into up to NAME_LENGTH plus
// EXT_LENGTH padding bytes, emitted by the back end at the same rate; input
// keeps flowing until the four-entry request queue between front and back end
// is full. Depends on dsnf_pkg, dsnf_front, dsnf_fifo and dsnf_back.
module dos_short_name_formatter_core #(
    parameter int NAME_LENGTH = 8,
    parameter int EXT_LENGTH  = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [11:8] position, [15:12] zero
    output logic        m_tlast    // last_of_name
);

    dsnf_pkg::cmd_t front_cmd, head_cmd;
    logic           accept, cmd_push, q_full, head_valid, pop;
    logic [7:0]     out_char;
    logic [3:0]     out_pos;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    dsnf_front #(
        .NAME_LENGTH (NAME_LENGTH),
        .EXT_LENGTH  (EXT_LENGTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_char  (s_tdata),
        .cmd      (front_cmd),
        .cmd_push (cmd_push)
    );

    dsnf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    dsnf_back #(
        .NAME_LENGTH (NAME_LENGTH),
        .EXT_LENGTH  (EXT_LENGTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .out_pos    (out_pos),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, out_pos, out_char};

endmodule

// ----- hdl/dsnf_front.sv -----
// Front end: accepts name bytes, tracks name/extension phase and fill count,
// and turns each byte into a request for the back end. Depends on dsnf_pkg.
module dsnf_front #(
    parameter int NAME_LENGTH = 8,
    parameter int EXT_LENGTH  = 3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic [7:0]     in_char,
    output dsnf_pkg::cmd_t cmd,
    output logic           cmd_push
);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_NAME  = 2'd1,
        PH_EXT   = 2'd2
    } phase_t;

    localparam dsnf_pkg::pos_t NAME_POS = dsnf_pkg::pos_t'(NAME_LENGTH);
    localparam dsnf_pkg::pos_t EXT_POS  = dsnf_pkg::pos_t'(EXT_LENGTH);
    localparam dsnf_pkg::pos_t FULL_POS = dsnf_pkg::pos_t'(NAME_LENGTH + EXT_LENGTH);

    phase_t         phase_reg, phase_next;
    dsnf_pkg::pos_t fill_reg, fill_next;

    logic           start;
    dsnf_pkg::pos_t fill_eff;
    logic [7:0]     mapped;

    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == 8'hE5) begin
            r = 8'h05;
        end else if (c > 8'h7E || c < 8'h21) begin
            r = 8'h00;
        end else if (c == 8'h22 || c == 8'h2A || c == 8'h2B || c == 8'h2C ||
                     c == 8'h2E || c == 8'h2F || (c >= 8'h3A && c <= 8'h3F) ||
                     c == 8'h5B || c == 8'h5C || c == 8'h5D || c == 8'h7C) begin
            r = 8'h00;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    assign start    = (phase_reg != PH_NAME) && (phase_reg != PH_EXT);
    assign fill_eff = start ? '0 : fill_reg;
    assign mapped   = map_char(in_char);

    always_comb begin
        cmd.has_char = 1'b0;
        cmd.ch       = dsnf_pkg::CH_UNDERSCORE;
        cmd.ch_pos   = '0;
        cmd.pad_lo   = '0;
        cmd.pad_hi   = '0;
        phase_next   = phase_reg;
        fill_next    = fill_reg;
        if (start || phase_reg == PH_NAME) begin
            priority if (in_char == dsnf_pkg::CH_NUL) begin
                cmd.pad_lo = fill_eff;
                cmd.pad_hi = FULL_POS;
                phase_next = PH_START;
                fill_next  = '0;
            end else if (in_char == dsnf_pkg::CH_DOT) begin
                // a leading dot becomes an underscore before the padding
                cmd.has_char = start;
                cmd.pad_lo   = start ? dsnf_pkg::pos_t'(1) : fill_eff;
                cmd.pad_hi   = NAME_POS;
                phase_next   = PH_EXT;
                fill_next    = '0;
            end else if (fill_eff < NAME_POS && mapped != 8'h00) begin
                cmd.has_char = 1'b1;
                cmd.ch       = mapped;
                cmd.ch_pos   = fill_eff;
                cmd.pad_lo   = NAME_POS;
                cmd.pad_hi   = NAME_POS;
                phase_next   = PH_NAME;
                fill_next    = fill_eff + 1'b1;
            end else begin
                phase_next = PH_NAME;
                fill_next  = fill_eff;
            end
        end else begin
            priority if (in_char == dsnf_pkg::CH_NUL) begin
                cmd.pad_lo = NAME_POS + fill_reg;
                cmd.pad_hi = FULL_POS;
                phase_next = PH_START;
                fill_next  = '0;
            end else if (fill_reg < EXT_POS && mapped != 8'h00) begin
                cmd.has_char = 1'b1;
                cmd.ch       = mapped;
                cmd.ch_pos   = NAME_POS + fill_reg;
                fill_next    = fill_reg + 1'b1;
            end else begin
                fill_next = fill_reg;
            end
        end
    end

    // requests that produce no bytes never enter the queue
    assign cmd_push = accept && (cmd.has_char || (cmd.pad_lo < cmd.pad_hi));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            fill_reg  <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// ----- hdl/dsnf_fifo.sv -----
// Short request queue between front and back end.
// Depends on dsnf_pkg for the request type and queue depth.
module dsnf_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dsnf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output dsnf_pkg::cmd_t head_cmd
);

    dsnf_pkg::cmd_t mem [dsnf_pkg::Q_DEPTH];

    logic [dsnf_pkg::Q_IDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [dsnf_pkg::Q_IDX_W:0]   count_reg;

    assign full       = (count_reg == (dsnf_pkg::Q_IDX_W+1)'(dsnf_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/dsnf_back.sv -----
// Back end: expands queued requests into short name bytes, one per cycle
// while the output is not stalled, into a registered output stage. Depends on dsnf_pkg.
module dsnf_back #(
    parameter int NAME_LENGTH = 8,
    parameter int EXT_LENGTH  = 3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  dsnf_pkg::cmd_t head_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_char,
    output logic [3:0]     out_pos,
    output logic           out_last
);

    localparam dsnf_pkg::pos_t LAST_POS = dsnf_pkg::pos_t'(NAME_LENGTH + EXT_LENGTH - 1);

    dsnf_pkg::cmd_t act_reg;
    logic           valid_reg;
    logic [7:0]     char_reg;
    dsnf_pkg::pos_t pos_reg;

    logic           work, adv, emit, rest;
    logic [7:0]     e_char;
    dsnf_pkg::pos_t e_pos;

    assign work   = act_reg.has_char || (act_reg.pad_lo < act_reg.pad_hi);
    assign adv    = !valid_reg || out_ready;
    assign emit   = adv && work;
    assign e_char = act_reg.has_char ? act_reg.ch : dsnf_pkg::CH_SPACE;
    assign e_pos  = act_reg.has_char ? act_reg.ch_pos : act_reg.pad_lo;
    assign rest   = act_reg.has_char ? (act_reg.pad_lo < act_reg.pad_hi)
                                     : ((act_reg.pad_lo + 1'b1) < act_reg.pad_hi);
    // take the next request as the current one hands over its last byte, or when none is active
    assign pop    = head_valid && (!work || (emit && !rest));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                act_reg <= head_cmd;
            end else if (emit) begin
                if (act_reg.has_char) begin
                    act_reg.has_char <= 1'b0;
                end else begin
                    act_reg.pad_lo <= act_reg.pad_lo + 1'b1;
                end
            end
            if (adv) begin
                valid_reg <= work;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            char_reg <= e_char;
            pos_reg  <= e_pos;
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_pos   = pos_reg[3:0];
    assign out_last  = (pos_reg == LAST_POS);

endmodule
